[design/hgcd_pkg.sv]
// shared fixed-point constants, the cordic word type and arctangent table for the distance pipeline
package hgcd_pkg;

    typedef logic signed [33:0] t_cordic;

    localparam t_cordic ONE_Q30 = 34'sd1073741824;
    localparam t_cordic HALF_PI_Q30 = 34'sd1686629713;
    localparam t_cordic CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [31:0] DEG_TO_RAD_Q36 = 32'sd1199381129;

    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] v;
        unique case (idx)
            0: v = 32'h3243F6A8;
            1: v = 32'h1DAC6705;
            2: v = 32'h0FADBAFC;
            3: v = 32'h07F56EA6;
            4: v = 32'h03FEAB76;
            5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;
            7: v = 32'h007FFF55;
            8: v = 32'h003FFFEA;
            9: v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[design/hgcd_sincos.sv]
// pipelined angle reduction and rotation cordic giving q30 sine and cosine
module hgcd_sincos
    import hgcd_pkg::*;
#(
    parameter int G = 24,
    parameter int STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [32:0] i_angle,
    output logic               o_valid,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    localparam int N = (STEPS < 32) ? STEPS : 32;
    localparam int LAT = N + 8;
    localparam longint FULL = 64'd360 << G;
    localparam longint HALF = 64'd180 << G;
    localparam longint QUARTER = 64'd90 << G;
    localparam longint MK = ((64'd1 << 32) + FULL - 1) / FULL;
    localparam longint MOFF = FULL * MK;
    localparam longint RECIP = ((64'd1 << 35) + FULL - 1) / FULL;
    localparam int RW = $clog2(RECIP + 1);
    localparam int DW = RW + 35;
    localparam int SH = 6 + G;
    localparam logic [33:0] FULL_C = FULL[33:0];
    localparam logic [33:0] HALF_C = HALF[33:0];
    localparam logic [33:0] QUARTER_C = QUARTER[33:0];
    localparam logic [33:0] UPPER_C = FULL_C - QUARTER_C;
    localparam logic [33:0] MOFF_C = MOFF[33:0];
    localparam logic [RW-1:0] RECIP_C = RECIP[RW-1:0];

    logic [LAT-1:0] r_vld;
    logic [34:0] r_u, r_u2, r_u3;
    logic [RW+34:0] r_qp;
    logic [RW+33:0] r_qf;
    logic [33:0] r_rem;
    logic signed [31:0] r_a;
    logic r_fa, r_fp;
    logic signed [63:0] r_prod;
    t_cordic r_x [0:N];
    t_cordic r_y [0:N];
    t_cordic r_z [0:N];
    logic r_f [0:N];
    logic signed [31:0] r_sin, r_cos;

    logic signed [35:0] n_u;
    logic [RW-1:0] n_q;
    logic [DW-1:0] n_diff;
    logic [33:0] n_rem;
    logic signed [34:0] n_a;
    logic n_flip;
    logic signed [63:0] n_zw;
    t_cordic n_yc, n_xc;

    always_comb begin
        n_u = $signed({{3{i_angle[32]}}, i_angle}) + $signed({2'b00, MOFF_C});
        n_q = r_qp[RW+34:35];
        n_diff = DW'(r_u3) - DW'(r_qf);
        n_rem = n_diff[DW-1] ? (n_diff[33:0] + FULL_C) : n_diff[33:0];
        n_flip = 1'b0;
        if (r_rem <= QUARTER_C) begin
            n_a = $signed({1'b0, r_rem});
        end else if (r_rem < UPPER_C) begin
            n_a = $signed({1'b0, HALF_C}) - $signed({1'b0, r_rem});
            n_flip = 1'b1;
        end else begin
            n_a = $signed({1'b0, r_rem}) - $signed({1'b0, FULL_C});
        end
        n_zw = r_prod >>> SH;
        n_yc = (r_y[N] > ONE_Q30) ? ONE_Q30 : ((r_y[N] < -ONE_Q30) ? -ONE_Q30 : r_y[N]);
        n_xc = (r_x[N] > ONE_Q30) ? ONE_Q30 : ((r_x[N] < -ONE_Q30) ? -ONE_Q30 : r_x[N]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u[34:0];
        r_qp <= (RW + 35)'(r_u) * (RW + 35)'(RECIP_C);
        r_u2 <= r_u;
        r_qf <= (RW + 34)'(n_q) * (RW + 34)'(FULL_C);
        r_u3 <= r_u2;
        r_rem <= n_rem;
        r_a <= n_a[31:0];
        r_fa <= n_flip;
        r_prod <= r_a * DEG_TO_RAD_Q36;
        r_fp <= r_fa;
        r_z[0] <= n_zw[33:0];
        r_x[0] <= CORDIC_GAIN_Q30;
        r_y[0] <= '0;
        r_f[0] <= r_fp;
        r_sin <= n_yc[31:0];
        r_cos <= r_f[N] ? -n_xc[31:0] : n_xc[31:0];
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (!r_z[i][33]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - $signed({2'b00, atan_q30(i)});
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + $signed({2'b00, atan_q30(i)});
            end
            r_f[i+1] <= r_f[i];
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

[design/hgcd_isqrt.sv]
// pipelined integer square root, one result bit per stage
module hgcd_isqrt #(
    parameter int W = 61
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [W-1:0]             i_n,
    output logic                     o_valid,
    output logic [(W+1)/2-1:0]       o_root
);

    localparam int HALF = (W + 1) / 2;

    logic [HALF:0] r_vld;
    logic [W-1:0] r_n [0:HALF];
    logic [W:0] r_r [0:HALF];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[HALF-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_n[0] <= i_n;
        r_r[0] <= '0;
    end

    for (genvar i = 0; i < HALF; i++) begin : g_bit
        localparam logic [W:0] B = (W + 1)'(1) << (2 * (HALF - 1 - i));
        logic [W+1:0] n_sum;
        assign n_sum = (W + 2)'(r_r[i]) + (W + 2)'(B);
        always_ff @(posedge i_clk) begin
            if ((W + 2)'(r_n[i]) >= n_sum) begin
                r_n[i+1] <= r_n[i] - n_sum[W-1:0];
                r_r[i+1] <= (r_r[i] >> 1) + B;
            end else begin
                r_n[i+1] <= r_n[i];
                r_r[i+1] <= r_r[i] >> 1;
            end
        end
    end

    assign o_valid = r_vld[HALF];
    assign o_root = r_r[HALF][HALF-1:0];

endmodule

[design/haversine_great_circle_distance_top.sv]
// great-circle distance pipeline: haversine term, square roots and arctangent cordic
//
// channel   direction  handshake               payload
// input     in         start, busy             i_lat_a, i_lon_a, i_lat_b, i_lon_b
// result    out        o_valid (one cycle)     o_distance
// config    in         i_cfg_we                i_cfg_wdata (sphere radius)
//
// one point pair per cycle; busy is always low
// the latency is set by the two cordic chains and the square root
// reset clears the valid bits and loads the radius with 6371 km
// results appear for one cycle and the receiver cannot stall them
module haversine_great_circle_distance_top
    import hgcd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 23,
    parameter int CORDIC_STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] i_lat_a,
    input  logic signed [31:0] i_lon_a,
    input  logic signed [30:0] i_lat_b,
    input  logic signed [31:0] i_lon_b,
    input  logic               i_cfg_we,
    input  logic [23:0]        i_cfg_wdata,
    output logic               o_valid,
    output logic [33:0]        o_distance
);

    localparam int N = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam logic [30:0] ONE31 = 31'd1073741824;

    logic [23:0] r_radius;
    logic r_v0, r_va, r_vb, r_vc, r_vd, r_vt, r_vp, r_vo;
    logic [N:0] r_vat;
    logic signed [32:0] r_dlat, r_dlon, r_lata, r_latb;
    logic v_dlat, v_dlon, v_lata, v_latb;
    logic signed [31:0] s_dlat, s_dlon, c_a, c_b;
    logic signed [63:0] r_p1, r_p2, r_pc, r_t;
    logic signed [31:0] r_sl, r_sd, r_cc, r_sl2;
    logic [30:0] r_h;
    logic v_sq, v_cq;
    logic [30:0] w_sq, w_cq;
    t_cordic r_ax [0:N];
    t_cordic r_ay [0:N];
    t_cordic r_az [0:N];
    logic [31:0] r_theta;
    logic [55:0] r_dprod;
    logic [33:0] r_dist;

    logic signed [63:0] n_sl, n_sd, n_cc, n_ts;
    logic signed [33:0] n_hs;
    logic [30:0] n_h;
    t_cordic n_zc;
    logic [56:0] n_dr;

    always_comb begin
        n_sl = r_p1 >>> 30;
        n_sd = r_p2 >>> 30;
        n_cc = r_pc >>> 30;
        n_ts = r_t >>> 30;
        n_hs = $signed({2'b00, r_sl2}) + n_ts[33:0];
        if (n_hs[33]) begin
            n_h = '0;
        end else if (n_hs > $signed({3'b000, ONE31})) begin
            n_h = ONE31;
        end else begin
            n_h = n_hs[30:0];
        end
        if (r_az[N][33]) begin
            n_zc = '0;
        end else if (r_az[N] > HALF_PI_Q30) begin
            n_zc = HALF_PI_Q30;
        end else begin
            n_zc = r_az[N];
        end
        n_dr = 57'(r_dprod) + 57'(22'd2097152);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 24'd1630976;
            r_v0 <= 1'b0;
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_vat <= '0;
            r_vt <= 1'b0;
            r_vp <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            r_v0 <= start && !busy;
            r_va <= v_dlat && v_dlon && v_lata && v_latb;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_vat <= {r_vat[N-1:0], v_sq && v_cq};
            r_vt <= r_vat[N];
            r_vp <= r_vt;
            r_vo <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dlat <= {{2{i_lat_b[30]}}, i_lat_b} - {{2{i_lat_a[30]}}, i_lat_a};
        r_dlon <= {i_lon_b[31], i_lon_b} - {i_lon_a[31], i_lon_a};
        r_lata <= {{2{i_lat_a[30]}}, i_lat_a};
        r_latb <= {{2{i_lat_b[30]}}, i_lat_b};
        r_p1 <= s_dlat * s_dlat;
        r_p2 <= s_dlon * s_dlon;
        r_pc <= c_a * c_b;
        r_sl <= n_sl[31:0];
        r_sd <= n_sd[31:0];
        r_cc <= n_cc[31:0];
        r_t <= r_cc * r_sd;
        r_sl2 <= r_sl;
        r_h <= n_h;
        r_ax[0] <= {3'b000, w_cq};
        r_ay[0] <= {3'b000, w_sq};
        r_az[0] <= '0;
        r_theta <= {n_zc[30:0], 1'b0};
        r_dprod <= 56'(r_theta) * 56'(r_radius);
        r_dist <= n_dr[55:22];
    end

    hgcd_sincos #(.G(ANGLE_FRAC_BITS + 1), .STEPS(CORDIC_STEPS)) u_sc_dlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0), .i_angle(r_dlat),
        .o_valid(v_dlat), .o_sin(s_dlat), .o_cos()
    );

    hgcd_sincos #(.G(ANGLE_FRAC_BITS + 1), .STEPS(CORDIC_STEPS)) u_sc_dlon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0), .i_angle(r_dlon),
        .o_valid(v_dlon), .o_sin(s_dlon), .o_cos()
    );

    hgcd_sincos #(.G(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_sc_lata (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0), .i_angle(r_lata),
        .o_valid(v_lata), .o_sin(), .o_cos(c_a)
    );

    hgcd_sincos #(.G(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_sc_latb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0), .i_angle(r_latb),
        .o_valid(v_latb), .o_sin(), .o_cos(c_b)
    );

    hgcd_isqrt #(.W(61)) u_sqrt_h (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_vd), .i_n({r_h, 30'd0}),
        .o_valid(v_sq), .o_root(w_sq)
    );

    hgcd_isqrt #(.W(61)) u_sqrt_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_vd), .i_n({ONE31 - r_h, 30'd0}),
        .o_valid(v_cq), .o_root(w_cq)
    );

    for (genvar i = 0; i < N; i++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (!r_ay[i][33] && (r_ay[i] != '0)) begin
                r_ax[i+1] <= r_ax[i] + (r_ay[i] >>> i);
                r_ay[i+1] <= r_ay[i] - (r_ax[i] >>> i);
                r_az[i+1] <= r_az[i] + $signed({2'b00, atan_q30(i)});
            end else begin
                r_ax[i+1] <= r_ax[i] - (r_ay[i] >>> i);
                r_ay[i+1] <= r_ay[i] + (r_ax[i] >>> i);
                r_az[i+1] <= r_az[i] - $signed({2'b00, atan_q30(i)});
            end
        end
    end

    assign busy = 1'b0;
    assign o_valid = r_vo;
    assign o_distance = r_dist;

`ifndef SYNTHESIS
    a_h_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vd |-> (r_h <= ONE31))
        else $error("haversine term out of range");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_sq && v_cq) |-> ((w_sq <= ONE31) && (w_cq <= ONE31)))
        else $error("square root out of range");

    a_theta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vt |-> (r_theta <= 32'd3373259426))
        else $error("central angle out of range");

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_vt, 2))
        else $error("result beat without matching angle beat");
`endif

endmodule
